// ===== rtl/lldisp_pkg.sv =====
package lldisp_pkg;

    // defaults for the top-level parameters
    localparam int MAX_MACHINES_DEF = 16;
    localparam int QUEUE_DEPTH_DEF  = 256;

    // fixed field widths
    localparam int TIME_W    = 16;
    localparam int LOAD_W    = 32;
    localparam int CFG_W     = 5;
    localparam int MACHINE_W = 4;
    localparam int SLOT_W    = 8;

    // stream payload widths (packed, padded to whole bytes)
    localparam int IN_TDATA_W  = 16;
    localparam int OUT_TDATA_W = 80;

    localparam logic [CFG_W-1:0] NUM_MACHINES_RST = 5'd16;

    // shared unit operations
    localparam logic ALU_LT  = 1'b0;
    localparam logic ALU_ADD = 1'b1;

    typedef struct packed {
        logic              op;
        logic [LOAD_W-1:0] a;
        logic [LOAD_W-1:0] b;
    } alu_req_t;

    typedef struct packed {
        logic              lt;   // a < b
        logic [LOAD_W-1:0] sum;  // a + b, saturating; 0 for ALU_LT
    } alu_rsp_t;

endpackage

// ===== rtl/lldisp_ram.sv =====
module lldisp_ram
    import lldisp_pkg::*;
#(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
)
(
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/lldisp_alu.sv =====
module lldisp_alu
    import lldisp_pkg::*;
(
    input  alu_req_t req,
    output alu_rsp_t rsp
);

    logic [LOAD_W:0] sum_full;

    // one 32-bit adder/comparator; add saturates on carry out
    always_comb
    begin
        sum_full = {1'b0, req.a} + {1'b0, req.b};
        rsp.lt   = (req.a < req.b);
        rsp.sum  = '0;
        case (req.op)
            ALU_ADD:
            begin
                rsp.sum = sum_full[LOAD_W] ? {LOAD_W{1'b1}} : sum_full[LOAD_W-1:0];
            end
            default:
            begin
                rsp.sum = '0;
            end
        endcase
    end

endmodule

// ===== rtl/least_loaded_task_dispatch_core.sv =====
// Sequencing: while the job is still filling its first machines, an input beat goes
//   through S_RDK, S_ADD, S_MAX and S_OUT to the output register; once the least-loaded
//   search runs, S_SCAN comes first. One task at a time; the search reads one load per
//   cycle through the load RAM's single read port and the one shared comparator.
// Reset: asynchronous, active low; clears the sequencer, job state and output valid
//   flag, sets num_machines to 16. Job tables clear instantly via valid bits.
module least_loaded_task_dispatch_core
    import lldisp_pkg::*;
#(
    parameter int MAX_MACHINES = MAX_MACHINES_DEF,
    parameter int QUEUE_DEPTH  = QUEUE_DEPTH_DEF
)
(
    input  logic                   clk,
    input  logic                   rst_n,

    // configuration: num_machines
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_W-1:0]       cfg_data,

    // task input
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,   // [15:0] task_time
    input  logic                   s_axis_tlast,   // last_task

    // dispatch result
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    output logic [OUT_TDATA_W-1:0] m_axis_tdata,   // [3:0] machine, [11:4] slot,
                                                   // [43:12] machine_load,
                                                   // [75:44] makespan, [79:76] zero
    output logic                   m_axis_tlast,   // job_done
    output logic                   m_axis_tuser    // queue_full
);

    localparam int IDX_W = $clog2(MAX_MACHINES);        // machine index
    localparam int MW    = $clog2(MAX_MACHINES + 1);    // machine count / tasks seen
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);     // per-machine task count
    localparam int ENT_W = CNT_W + LOAD_W;              // RAM entry {count, load}

    // sequencer states
    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_SCAN = 3'd1;   // stream loads through comparator
    localparam logic [2:0] S_RDK  = 3'd2;   // read chosen machine entry
    localparam logic [2:0] S_ADD  = 3'd3;   // add task time, write back
    localparam logic [2:0] S_MAX  = 3'd4;   // update makespan
    localparam logic [2:0] S_OUT  = 3'd5;   // hand result to output register

    logic [2:0]              state_reg, state_next;
    logic [CFG_W-1:0]        num_machines_reg, num_machines_next;
    logic [TIME_W-1:0]       time_reg, time_next;
    logic                    last_reg, last_next;
    logic [IDX_W-1:0]        last_idx_reg, last_idx_next;
    logic [MW-1:0]           tasks_seen_reg, tasks_seen_next;
    logic [IDX_W-1:0]        addr_reg, addr_next;
    logic [IDX_W-1:0]        dph_reg, dph_next;
    logic                    dv_reg, dv_next;
    logic [IDX_W-1:0]        best_reg, best_next;
    logic [LOAD_W-1:0]       best_load_reg, best_load_next;
    logic [IDX_W-1:0]        k_reg, k_next;
    logic [LOAD_W-1:0]       new_load_reg, new_load_next;
    logic [CNT_W-1:0]        slot_reg, slot_next;
    logic                    full_reg, full_next;
    logic [LOAD_W-1:0]       max_load_reg, max_load_next;
    logic [MAX_MACHINES-1:0] valid_reg, valid_next;

    logic                    out_valid_reg, out_valid_next;
    logic [MACHINE_W-1:0]    out_machine_reg, out_machine_next;
    logic [SLOT_W-1:0]       out_slot_reg, out_slot_next;
    logic [LOAD_W-1:0]       out_load_reg, out_load_next;
    logic [LOAD_W-1:0]       out_span_reg, out_span_next;
    logic                    out_done_reg, out_done_next;
    logic                    out_full_reg, out_full_next;

    // effective machine count
    logic [31:0]             cfg_ext;
    logic [MW-1:0]           m_eff;
    logic                    direct;

    // RAM and shared unit
    logic                    ram_we;
    logic [IDX_W-1:0]        ram_raddr;
    logic [ENT_W-1:0]        ram_wdata;
    logic [ENT_W-1:0]        ram_rdata;
    logic [IDX_W-1:0]        ent_idx;
    logic [LOAD_W-1:0]       ent_load;
    logic [CNT_W-1:0]        ent_cnt;
    logic                    ent_full;
    logic                    take_new;
    alu_req_t                alu_req;
    alu_rsp_t                alu_rsp;

    logic                    in_fire;
    logic                    out_free;

    assign cfg_ready     = 1'b1;
    assign s_axis_tready = (state_reg == S_IDLE);
    assign in_fire       = s_axis_tvalid && s_axis_tready;
    assign out_free      = !out_valid_reg || m_axis_tready;

    // clamp num_machines to 1..MAX_MACHINES
    always_comb
    begin
        cfg_ext = 32'(num_machines_reg);
        if (cfg_ext == 32'd0)
        begin
            m_eff = MW'(1);
        end
        else if (cfg_ext > 32'(MAX_MACHINES))
        begin
            m_eff = MW'(MAX_MACHINES);
        end
        else
        begin
            m_eff = MW'(cfg_ext);
        end
    end

    // first tasks of a job go straight to machine number tasks_seen
    assign direct = (tasks_seen_reg < m_eff);

    // one read port: scan address while searching, chosen machine otherwise
    assign ram_raddr = (state_reg == S_SCAN) ? addr_reg : k_reg;

    // read data belongs to the previous cycle's address; never-written entries read 0
    assign ent_idx  = (state_reg == S_SCAN) ? dph_reg : k_reg;
    assign ent_load = valid_reg[ent_idx] ? ram_rdata[LOAD_W-1:0] : '0;
    assign ent_cnt  = valid_reg[ent_idx] ? ram_rdata[ENT_W-1:LOAD_W] : '0;
    assign ent_full = (ent_cnt >= CNT_W'(QUEUE_DEPTH));

    lldisp_ram #(
        .WIDTH (ENT_W),
        .DEPTH (MAX_MACHINES)
    ) u_load_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (k_reg),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // shared comparator / saturating adder
    always_comb
    begin
        alu_req.op = ALU_LT;
        alu_req.a  = ent_load;
        alu_req.b  = best_load_reg;
        case (state_reg)
            S_ADD:
            begin
                alu_req.op = ALU_ADD;
                alu_req.a  = ent_load;
                alu_req.b  = LOAD_W'(time_reg);
            end
            S_MAX:
            begin
                alu_req.op = ALU_LT;
                alu_req.a  = max_load_reg;
                alu_req.b  = new_load_reg;
            end
            default:
            begin
                alu_req.op = ALU_LT;
                alu_req.a  = ent_load;
                alu_req.b  = best_load_reg;
            end
        endcase
    end

    lldisp_alu u_alu (
        .req (alu_req),
        .rsp (alu_rsp)
    );

    // strict less-than keeps the lowest index on ties; index 0 seeds the search
    assign take_new = (dph_reg == '0) || alu_rsp.lt;

    assign ram_wdata = {ent_cnt + CNT_W'(1), alu_rsp.sum};

    always_comb
    begin
        state_next        = state_reg;
        num_machines_next = num_machines_reg;
        time_next         = time_reg;
        last_next         = last_reg;
        last_idx_next     = last_idx_reg;
        tasks_seen_next   = tasks_seen_reg;
        addr_next         = addr_reg;
        dph_next          = dph_reg;
        dv_next           = dv_reg;
        best_next         = best_reg;
        best_load_next    = best_load_reg;
        k_next            = k_reg;
        new_load_next     = new_load_reg;
        slot_next         = slot_reg;
        full_next         = full_reg;
        max_load_next     = max_load_reg;
        valid_next        = valid_reg;
        ram_we            = 1'b0;

        out_valid_next    = out_valid_reg && !m_axis_tready;
        out_machine_next  = out_machine_reg;
        out_slot_next     = out_slot_reg;
        out_load_next     = out_load_reg;
        out_span_next     = out_span_reg;
        out_done_next     = out_done_reg;
        out_full_next     = out_full_reg;

        if (cfg_valid && cfg_ready)
        begin
            num_machines_next = cfg_data;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                begin
                    time_next     = s_axis_tdata[TIME_W-1:0];
                    last_next     = s_axis_tlast;
                    last_idx_next = IDX_W'(m_eff - MW'(1));
                    if (direct)
                    begin
                        k_next     = IDX_W'(tasks_seen_reg);
                        state_next = S_RDK;
                    end
                    else
                    begin
                        addr_next  = '0;
                        dv_next    = 1'b0;
                        state_next = S_SCAN;
                    end
                end
            end
            S_SCAN:
            begin
                if (dv_reg && take_new)
                begin
                    best_next      = dph_reg;
                    best_load_next = ent_load;
                end
                if (dv_reg && (dph_reg == last_idx_reg))
                begin
                    k_next     = take_new ? dph_reg : best_reg;
                    state_next = S_RDK;
                end
                else
                begin
                    dph_next = addr_reg;
                    dv_next  = 1'b1;
                    if (addr_reg != last_idx_reg)
                    begin
                        addr_next = addr_reg + IDX_W'(1);
                    end
                end
            end
            S_RDK:
            begin
                state_next = S_ADD;
            end
            S_ADD:
            begin
                // full queue rejects the task: entry untouched, slot reads 0
                full_next = ent_full;
                if (ent_full)
                begin
                    new_load_next = ent_load;
                    slot_next     = '0;
                end
                else
                begin
                    new_load_next     = alu_rsp.sum;
                    slot_next         = ent_cnt;
                    ram_we            = 1'b1;
                    valid_next[k_reg] = 1'b1;
                end
                state_next = S_MAX;
            end
            S_MAX:
            begin
                if (alu_rsp.lt)
                begin
                    max_load_next = new_load_reg;
                end
                state_next = S_OUT;
            end
            S_OUT:
            begin
                if (out_free)
                begin
                    out_valid_next   = 1'b1;
                    out_machine_next = MACHINE_W'(k_reg);
                    out_slot_next    = SLOT_W'(slot_reg);
                    out_load_next    = new_load_reg;
                    out_span_next    = max_load_reg;
                    out_done_next    = last_reg;
                    out_full_next    = full_reg;
                    if (last_reg)
                    begin
                        // job closes: drop all loads, counts and the makespan
                        valid_next      = '0;
                        tasks_seen_next = '0;
                        max_load_next   = '0;
                    end
                    else if (tasks_seen_reg < MW'(MAX_MACHINES))
                    begin
                        tasks_seen_next = tasks_seen_reg + MW'(1);
                    end
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            num_machines_reg <= NUM_MACHINES_RST;
            tasks_seen_reg   <= '0;
            max_load_reg     <= '0;
            valid_reg        <= '0;
            dv_reg           <= 1'b0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            num_machines_reg <= num_machines_next;
            tasks_seen_reg   <= tasks_seen_next;
            max_load_reg     <= max_load_next;
            valid_reg        <= valid_next;
            dv_reg           <= dv_next;
            out_valid_reg    <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        time_reg        <= time_next;
        last_reg        <= last_next;
        last_idx_reg    <= last_idx_next;
        addr_reg        <= addr_next;
        dph_reg         <= dph_next;
        best_reg        <= best_next;
        best_load_reg   <= best_load_next;
        k_reg           <= k_next;
        new_load_reg    <= new_load_next;
        slot_reg        <= slot_next;
        full_reg        <= full_next;
        out_machine_reg <= out_machine_next;
        out_slot_reg    <= out_slot_next;
        out_load_reg    <= out_load_next;
        out_span_reg    <= out_span_next;
        out_done_reg    <= out_done_next;
        out_full_reg    <= out_full_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {{(OUT_TDATA_W - MACHINE_W - SLOT_W - 2*LOAD_W){1'b0}},
                            out_span_reg, out_load_reg, out_slot_reg, out_machine_reg};
    assign m_axis_tlast  = out_done_reg;
    assign m_axis_tuser  = out_full_reg;

`ifndef NO_ASSERTIONS
    // a rejected task never reports a queue slot
    a_full_slot_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tuser) |-> (m_axis_tdata[11:4] == '0))
        else $error("queue_full result with nonzero slot");

    // makespan always covers the reported machine load
    a_span_covers_load: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (m_axis_tdata[75:44] >= m_axis_tdata[43:12]))
        else $error("makespan below machine load");

    // one task at a time: busy right after an accepted beat
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("input accepted while busy");

    // task counter saturates at MAX_MACHINES
    a_tasks_seen_bound: assert property (@(posedge clk) disable iff (!rst_n)
        tasks_seen_reg <= MW'(MAX_MACHINES))
        else $error("tasks_seen overflow");
`endif

endmodule
